// File: hdl/hcpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcpt_pkg: shared types and constants
// Constants of the FNV-1a context hash, the Q0.16 probability format and the
// request struct that drives the shared multiplier unit.
// ---------------------------------------------------------------------------
package hcpt_pkg;

  // fnv-1a 32-bit hash constants
  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // probability format and count limit
  localparam logic [15:0] HALF_Q16  = 16'h8000;
  localparam logic [16:0] ONE_Q16   = 17'h1_0000;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  // table entry: probability in the upper bits, count in the lower bits
  localparam int ENTRY_W = 24;

  // operations of the shared multiplier
  typedef enum logic [2:0] {
    MOP_HOLD,
    MOP_HASH_FIRST,
    MOP_HASH_NEXT,
    MOP_RECIP,
    MOP_BACK
  } mul_op_t;

  // request from the sequencer to the multiplier unit
  typedef struct packed {
    mul_op_t     op;
    logic [7:0]  data_byte;
    logic [16:0] numer;
    logic [7:0]  count;
  } mul_req_t;

endpackage
`default_nettype wire

// File: hdl/hcpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcpt_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ---------------------------------------------------------------------------
interface hcpt_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] newest_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] partial_byte;
  logic       coded_bit;

  modport source (
    output valid, req_type, newest_byte, second_byte, third_byte, partial_byte,
           coded_bit,
    input  ready
  );
  modport sink (
    input  valid, req_type, newest_byte, second_byte, third_byte, partial_byte,
           coded_bit,
    output ready
  );
endinterface

interface hcpt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic [7:0]  entry_count;

  modport source (
    output valid, probability, entry_count,
    input  ready
  );
  modport sink (
    input  valid, probability, entry_count,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/hcpt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcpt_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hcpt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/hcpt_mul_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hcpt_mul_unit: shared 32x32 multiplier
// Runs the fnv-1a hash rounds, the reciprocal multiply of the divide and the
// back multiply of the remainder check. The product register feeds the next
// hash round directly.
// ---------------------------------------------------------------------------
module hcpt_mul_unit (
  input  wire logic              clk,
  input  wire hcpt_pkg::mul_req_t req,
  output logic        [63:0]     prod
);

  logic [31:0] recip_tab [256];
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [8:0]  divisor;
  logic [63:0] prod_nxt;
  logic [63:0] prod_r;

  // reciprocal table: floor(2^32 / (count + 2))
  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam logic [31:0] RECIP_VAL = 32'(64'd4294967296 / 64'(g + 2));
    assign recip_tab[g] = RECIP_VAL;
  end

  assign divisor = {1'b0, req.count} + 9'd2;

  // operand selection
  always_comb begin
    case (req.op)
      hcpt_pkg::MOP_HASH_FIRST: begin
        op_a = hcpt_pkg::FNV_BASIS ^ {24'd0, req.data_byte};
        op_b = hcpt_pkg::FNV_PRIME;
      end
      hcpt_pkg::MOP_HASH_NEXT: begin
        op_a = prod_r[31:0] ^ {24'd0, req.data_byte};
        op_b = hcpt_pkg::FNV_PRIME;
      end
      hcpt_pkg::MOP_RECIP: begin
        op_a = {15'd0, req.numer};
        op_b = recip_tab[req.count];
      end
      hcpt_pkg::MOP_BACK: begin
        op_a = {15'd0, prod_r[48:32]};
        op_b = {23'd0, divisor};
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
    endcase
  end

  assign prod_nxt = {32'd0, op_a} * {32'd0, op_b};

  // product register
  always_ff @(posedge clk) begin
    if (req.op != hcpt_pkg::MOP_HOLD) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// File: hdl/hashed_context_probability_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hashed_context_probability_table: hashed adaptive probability table
// Hashes a byte context with fnv-1a, reads a probability/count entry and on
// update moves the probability toward the coded bit by diff / (count + 2).
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  in_chan   sink       valid/ready    req_type, three history bytes,
//                                      partial_byte, coded_bit
//  out_chan  source     valid/ready    probability, entry_count
//
//  A predict runs four hash rounds and the table read; an update adds the
//  reciprocal multiply, back multiply, correction and write. The hash rounds
//  and both multiplies share the one 32x32 multiplier. After reset all
//  2^SLOT_BITS entries are swept; in_chan is not ready during the sweep.
//  A held result does not block the next request until its own result is due.
//  A new request is taken only in the idle state, once the last result is loaded.
// ---------------------------------------------------------------------------
module hashed_context_probability_table #(
  parameter int SLOT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hcpt_in_if.sink   in_chan,
  hcpt_out_if.source out_chan
);

  localparam int DEPTH = 1 << SLOT_BITS;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ADDR,
    S_READ,
    S_RECIP,
    S_BACK,
    S_FIX,
    S_WRITE,
    S_OUT
  } state_t;

  state_t                          state_r;
  logic [SLOT_BITS-1:0]            clr_r;
  logic [1:0]                      step_r;
  logic                            req_r;
  logic                            coded_r;
  logic [7:0]                      newest_r;
  logic [7:0]                      second_r;
  logic [7:0]                      third_r;
  logic [7:0]                      partial_r;
  logic [SLOT_BITS-1:0]            slot_r;
  logic [15:0]                     p_r;
  logic [7:0]                      n_r;
  logic [16:0]                     quot_r;
  logic [9:0]                      rem_r;
  logic                            out_valid_r;
  logic [15:0]                     out_prob_r;
  logic [7:0]                      out_count_r;

  hcpt_pkg::mul_req_t              mreq;
  logic [63:0]                     prod;
  logic [7:0]                      hash_byte;
  logic [31:0]                     fold_w;
  logic [16:0]                     x_w;
  logic [8:0]                      d_w;
  logic [16:0]                     rem_full_w;
  logic [16:0]                     q_w;
  logic [16:0]                     sum_w;
  logic [15:0]                     new_prob_w;
  logic [7:0]                      new_count_w;
  logic                            ram_we;
  logic [SLOT_BITS-1:0]            ram_waddr;
  logic [hcpt_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [hcpt_pkg::ENTRY_W-1:0]    ram_rdata;

  // channel outputs
  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.probability = out_prob_r;
  assign out_chan.entry_count = out_count_r;

  // byte for the current hash round: the history bytes, then the partial byte
  always_comb begin
    case (step_r)
      2'd0:    hash_byte = newest_r;
      2'd1:    hash_byte = second_r;
      2'd2:    hash_byte = third_r;
      default: hash_byte = partial_r;
    endcase
  end

  // multiplier requests from the sequencer
  always_comb begin
    mreq.data_byte = hash_byte;
    mreq.numer     = x_w;
    mreq.count     = n_r;
    case (state_r)
      S_HASH:  mreq.op = (step_r == 2'd0) ? hcpt_pkg::MOP_HASH_FIRST
                                          : hcpt_pkg::MOP_HASH_NEXT;
      S_RECIP: mreq.op = hcpt_pkg::MOP_RECIP;
      S_BACK:  mreq.op = hcpt_pkg::MOP_BACK;
      default: mreq.op = hcpt_pkg::MOP_HOLD;
    endcase
  end

  hcpt_mul_unit u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // hash fold and update arithmetic
  assign fold_w      = prod[31:0] ^ (prod[31:0] >> 16);
  assign x_w         = coded_r ? (hcpt_pkg::ONE_Q16 - {1'b0, p_r}) : {1'b0, p_r};
  assign d_w         = {1'b0, n_r} + 9'd2;
  assign rem_full_w  = x_w - prod[16:0];
  assign q_w         = quot_r + ((rem_r >= {1'b0, d_w}) ? 17'd1 : 17'd0);
  assign sum_w       = coded_r ? ({1'b0, p_r} + q_w) : ({1'b0, p_r} - q_w);
  assign new_prob_w  = sum_w[16] ? 16'hFFFF : sum_w[15:0];
  assign new_count_w = (n_r == hcpt_pkg::COUNT_MAX) ? n_r : (n_r + 8'd1);

  // table write: clearing sweep or entry update
  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : slot_r;
  assign ram_wdata = (state_r == S_CLEAR) ? {hcpt_pkg::HALF_Q16, 8'd0}
                                          : {new_prob_w, new_count_w};

  hcpt_ram #(
    .WIDTH (hcpt_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (fold_w[SLOT_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: load a new result or drop the one taken
      if ((state_r == S_OUT) && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            req_r     <= in_chan.req_type;
            coded_r   <= in_chan.coded_bit;
            newest_r  <= in_chan.newest_byte;
            second_r  <= in_chan.second_byte;
            third_r   <= in_chan.third_byte;
            partial_r <= in_chan.partial_byte;
            step_r    <= 2'd0;
            state_r   <= S_HASH;
          end
        end
        S_HASH: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          slot_r  <= fold_w[SLOT_BITS-1:0];
          state_r <= S_READ;
        end
        S_READ: begin
          p_r     <= ram_rdata[23:8];
          n_r     <= ram_rdata[7:0];
          state_r <= req_r ? S_RECIP : S_OUT;
        end
        S_RECIP: begin
          state_r <= S_BACK;
        end
        S_BACK: begin
          quot_r  <= prod[48:32];
          state_r <= S_FIX;
        end
        S_FIX: begin
          rem_r   <= rem_full_w[9:0];
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_prob_r  <= p_r;
            out_count_r <= n_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the clearing sweep runs to its last entry before requests are taken
  a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_r != '1) |=> (state_r == S_CLEAR))
    else $error("clearing sweep left early");

  // reciprocal quotient is at most one short, so the remainder stays below 2*d
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (rem_r < {d_w, 1'b0}))
    else $error("divide remainder out of range");

  // an update moves the probability toward the coded bit
  a_direction: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (coded_r ? (new_prob_w >= p_r) : (new_prob_w <= p_r)))
    else $error("probability moved away from coded bit");

  // a result appears only from the output step of the sequencer
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output step");
`endif

endmodule
`default_nettype wire
